@@ design/aapr_pkg.sv @@
// ----------------------------------------------------------------------------
// aapr_pkg: shared types and constants of the axis-angle point rotator
// Fixed-point constants in Q30, arctangent table of the CORDIC and the
// records that travel along the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aapr_pkg;

    localparam int COORD_BITS   = 32;
    localparam int SQRT_BITS    = 64;
    localparam int SQRT_STEPS   = 32;
    localparam int LEN_BITS     = 32;
    localparam int QUOT_BITS    = 31;
    localparam int DIV_REM_BITS = 62;
    localparam int CORDIC_BITS  = 34;
    localparam int MAX_CORDIC   = 32;

    localparam logic [32:0] ANG_TWO_PI  = 33'd6746518852;
    localparam logic [32:0] ANG_PI      = 33'd3373259426;
    localparam logic [32:0] ANG_HALF_PI = 33'd1686629713;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [33:0] Q30_ONE     = 34'd1073741824;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               zero;
        logic [2:0]         sgn;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [2:0][31:0] mag;
        logic            neg;
    } p1_t;

    typedef struct packed {
        side_t       side;
        logic [31:0] len;
        logic        flip;
    } p2_t;

    function automatic logic [31:0] atan_entry(input int step);
        logic [31:0] v;
        case (step)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/aapr_ifs.sv @@
// ----------------------------------------------------------------------------
// aapr_ifs: item channels of the axis-angle point rotator
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface aapr_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] turn_angle;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;

    modport source (output valid, point_x, point_y, point_z, turn_angle,
                    axis_x, axis_y, axis_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, turn_angle,
                  axis_x, axis_y, axis_z, output ready);
endinterface

interface aapr_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               axis_error;

    modport source (output valid, rotated_x, rotated_y, rotated_z, axis_error,
                    input ready);
    modport sink (input valid, rotated_x, rotated_y, rotated_z, axis_error,
                  output ready);
endinterface

`default_nettype wire

@@ design/aapr_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// aapr_sqrt_cell: one digit of the integer square root
// Tries one result bit against the remaining radicand and registers both.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_sqrt_cell #(
    parameter int SHIFT = 62
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [aapr_pkg::SQRT_BITS-1:0] v_in,
    input  logic [aapr_pkg::SQRT_BITS-1:0] res_in,
    output logic [aapr_pkg::SQRT_BITS-1:0] v_out,
    output logic [aapr_pkg::SQRT_BITS-1:0] res_out
);
    import aapr_pkg::*;

    localparam logic [SQRT_BITS-1:0] BIT_VAL = SQRT_BITS'(1) << SHIFT;

    logic [SQRT_BITS:0]   trial;
    logic [SQRT_BITS-1:0] v_next;
    logic [SQRT_BITS-1:0] res_next;
    logic [SQRT_BITS-1:0] v_reg;
    logic [SQRT_BITS-1:0] res_reg;

    always_comb
    begin
        trial = {1'b0, res_in} + {1'b0, BIT_VAL};
        if ({1'b0, v_in} >= trial)
        begin
            v_next   = v_in - trial[SQRT_BITS-1:0];
            res_next = (res_in >> 1) + BIT_VAL;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

@@ design/aapr_mod_cell.sv @@
// ----------------------------------------------------------------------------
// aapr_mod_cell: one step of the reduction modulo two pi
// Subtracts a shifted copy of two pi when it fits into the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_mod_cell #(
    parameter int W     = 46,
    parameter int SHIFT = 0
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] rem_in,
    output logic [W-1:0] rem_out
);
    import aapr_pkg::*;

    localparam logic [W-1:0] STEP_VAL = W'(ANG_TWO_PI) << SHIFT;

    logic [W-1:0] rem_next;
    logic [W-1:0] rem_reg;

    assign rem_next = (rem_in >= STEP_VAL) ? rem_in - STEP_VAL : rem_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
        end
    end

    assign rem_out = rem_reg;

endmodule

`default_nettype wire

@@ design/aapr_div_cell.sv @@
// ----------------------------------------------------------------------------
// aapr_div_cell: one quotient bit of the axis normalization
// Restoring division step against the axis length shifted into place.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_div_cell #(
    parameter int SHIFT = 30
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [aapr_pkg::LEN_BITS-1:0]     len,
    input  logic [aapr_pkg::DIV_REM_BITS-1:0] rem_in,
    input  logic [aapr_pkg::QUOT_BITS-1:0]    q_in,
    output logic [aapr_pkg::DIV_REM_BITS-1:0] rem_out,
    output logic [aapr_pkg::QUOT_BITS-1:0]    q_out
);
    import aapr_pkg::*;

    localparam logic [QUOT_BITS-1:0] Q_BIT = QUOT_BITS'(1) << SHIFT;

    logic [DIV_REM_BITS-1:0] dvs;
    logic [DIV_REM_BITS-1:0] rem_reg;
    logic [QUOT_BITS-1:0]    q_reg;

    assign dvs = DIV_REM_BITS'(len) << SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_in >= dvs)
            begin
                rem_reg <= rem_in - dvs;
                q_reg   <= q_in | Q_BIT;
            end
            else
            begin
                rem_reg <= rem_in;
                q_reg   <= q_in;
            end
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

@@ design/aapr_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// aapr_cordic_cell: one micro-rotation of the sine and cosine CORDIC
// Rotates the vector toward the residual angle by a fixed arctangent.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [aapr_pkg::CORDIC_BITS-1:0] x_in,
    input  logic signed [aapr_pkg::CORDIC_BITS-1:0] y_in,
    input  logic signed [aapr_pkg::CORDIC_BITS-1:0] r_in,
    output logic signed [aapr_pkg::CORDIC_BITS-1:0] x_out,
    output logic signed [aapr_pkg::CORDIC_BITS-1:0] y_out,
    output logic signed [aapr_pkg::CORDIC_BITS-1:0] r_out
);
    import aapr_pkg::*;

    localparam logic signed [CORDIC_BITS-1:0] ATAN = $signed({2'b00, atan_entry(STEP)});

    logic signed [CORDIC_BITS-1:0] dx;
    logic signed [CORDIC_BITS-1:0] dy;
    logic signed [CORDIC_BITS-1:0] x_reg;
    logic signed [CORDIC_BITS-1:0] y_reg;
    logic signed [CORDIC_BITS-1:0] r_reg;

    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r_in >= 0)
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                r_reg <= r_in - ATAN;
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                r_reg <= r_in + ATAN;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign r_out = r_reg;

endmodule

`default_nettype wire

@@ design/axis_angle_point_rotator_top.sv @@
// ----------------------------------------------------------------------------
// axis_angle_point_rotator_top: Rodrigues rotation of a point about an axis
//
//   channel   dir   payload
//   request   in    point_x/y/z, turn_angle, axis_x/y/z (signed Q16.16)
//   result    out   rotated_x/y/z (saturated), axis_error
//
// One item enters per cycle while no result waits at the output. The
// pipeline has 32 square-root cells followed by the 31 divider cells, which
// run beside the CORDIC cells. The angle reduction runs beside the root.
// Reset clears only the valid bits of the stages and the output register.
// A result waiting at the output holds the whole pipeline; the first stage
// still takes one item when it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_point_rotator_top #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    aapr_req_if.sink   request,
    aapr_res_if.source result
);
    import aapr_pkg::*;

    localparam int SH        = 30 - FRACTION_BITS;
    localparam int MW        = 32 + SH;
    localparam int MOD_STEPS = SH;
    localparam int NSTEP     = (CORDIC_STEPS > MAX_CORDIC) ? MAX_CORDIC : CORDIC_STEPS;
    localparam int P2        = (NSTEP > QUOT_BITS) ? NSTEP : QUOT_BITS;
    localparam int SUM_W     = 70;

    localparam logic signed [CORDIC_BITS-1:0] ONE34 = $signed(Q30_ONE);
    localparam logic signed [31:0]            ONE32 = 32'sd1073741824;

    function automatic logic [31:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        logic [31:0]             o;
        v = (s + 70'sd134217728) >>> 28;
        if (v > 70'sd2147483647)
            o = 32'h7FFFFFFF;
        else if (v < -70'sd2147483648)
            o = 32'h80000000;
        else
            o = v[31:0];
        return o;
    endfunction

    logic adv;
    logic en0;
    logic out_vld_reg;
    logic v0_reg;

    assign adv           = !out_vld_reg || result.ready;
    assign en0           = adv || !v0_reg;
    assign request.ready = en0;

    // ---------------- input capture ----------------
    logic signed [31:0] s0_p_reg [3];
    logic signed [31:0] s0_a_reg [3];
    logic signed [31:0] s0_ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en0)
            v0_reg <= request.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_p_reg[0] <= request.point_x;
            s0_p_reg[1] <= request.point_y;
            s0_p_reg[2] <= request.point_z;
            s0_a_reg[0] <= request.axis_x;
            s0_a_reg[1] <= request.axis_y;
            s0_a_reg[2] <= request.axis_z;
            s0_ang_reg  <= request.turn_angle;
        end
    end

    // ---------------- squares, magnitudes ----------------
    logic [31:0]    s1_mag [3];
    logic [63:0]    s1_sq  [3];
    logic [31:0]    s1_amag32;
    logic           v1_reg;
    logic [63:0]    s1_sq_reg [3];
    p1_t            s1_c_reg;
    logic [MW-1:0]  s1_amag_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            s1_mag[l] = s0_a_reg[l][31] ? 32'(-s0_a_reg[l]) : s0_a_reg[l];
            s1_sq[l]  = s1_mag[l] * s1_mag[l];
        end
        s1_amag32 = s0_ang_reg[31] ? 32'(-s0_ang_reg) : s0_ang_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                s1_sq_reg[l]       <= s1_sq[l];
                s1_c_reg.mag[l]    <= s1_mag[l];
                s1_c_reg.side.sgn[l] <= s0_a_reg[l][31];
            end
            s1_c_reg.side.px   <= s0_p_reg[0];
            s1_c_reg.side.py   <= s0_p_reg[1];
            s1_c_reg.side.pz   <= s0_p_reg[2];
            s1_c_reg.side.zero <= (s0_a_reg[0] == 0) && (s0_a_reg[1] == 0)
                                  && (s0_a_reg[2] == 0);
            s1_c_reg.neg       <= s0_ang_reg[31];
            s1_amag_reg        <= MW'(s1_amag32) << SH;
        end
    end

    // ---------------- sum of squares ----------------
    logic           v2_reg;
    logic [63:0]    s2_sum_reg;
    p1_t            s2_c_reg;
    logic [MW-1:0]  s2_amag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sum_reg  <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
            s2_c_reg    <= s1_c_reg;
            s2_amag_reg <= s1_amag_reg;
        end
    end

    // ---------------- square root and angle reduction cells ----------------
    logic [SQRT_BITS-1:0] sqv  [SQRT_STEPS+1];
    logic [SQRT_BITS-1:0] sqr  [SQRT_STEPS+1];
    logic [MW-1:0]        modr [SQRT_STEPS+1];
    p1_t                  p1c  [SQRT_STEPS+1];
    logic                 vld1 [SQRT_STEPS+1];

    assign sqv[0]  = s2_sum_reg;
    assign sqr[0]  = '0;
    assign modr[0] = s2_amag_reg;
    assign p1c[0]  = s2_c_reg;
    assign vld1[0] = v2_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_p1
        p1_t  c_reg;
        logic v_reg;

        aapr_sqrt_cell #(.SHIFT(62 - 2 * k)) u_sqrt (
            .clk     (clk),
            .en      (adv),
            .v_in    (sqv[k]),
            .res_in  (sqr[k]),
            .v_out   (sqv[k+1]),
            .res_out (sqr[k+1])
        );

        if (k < MOD_STEPS)
        begin : g_mod
            aapr_mod_cell #(.W(MW), .SHIFT(MOD_STEPS - 1 - k)) u_mod (
                .clk     (clk),
                .en      (adv),
                .rem_in  (modr[k]),
                .rem_out (modr[k+1])
            );
        end
        else
        begin : g_mod_pass
            logic [MW-1:0] m_reg;
            always_ff @(posedge clk)
            begin
                if (adv)
                    m_reg <= modr[k];
            end
            assign modr[k+1] = m_reg;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                c_reg <= p1c[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= vld1[k];
        end

        assign p1c[k+1]  = c_reg;
        assign vld1[k+1] = v_reg;
    end

    // ---------------- angle fold into [-pi/2, pi/2] ----------------
    logic [32:0]        rm;
    logic signed [34:0] rw;
    logic signed [34:0] rf;
    logic               fl;
    logic               f_vld_reg;
    logic [31:0]        f_len_reg;
    logic signed [CORDIC_BITS-1:0] f_r_reg;
    logic               f_flip_reg;
    logic [2:0][31:0]   f_mag_reg;
    side_t              f_side_reg;

    assign rm = modr[SQRT_STEPS][32:0];

    always_comb
    begin
        // Floored remainder first, then a full turn is taken off a remainder above pi.
        if (p1c[SQRT_STEPS].neg && (rm != 0))
            rw = (rm < ANG_PI) ? -$signed({2'b00, rm})
                               : $signed({2'b00, ANG_TWO_PI - rm});
        else
            rw = (rm > ANG_PI) ? $signed({2'b00, rm}) - $signed({2'b00, ANG_TWO_PI})
                               : $signed({2'b00, rm});
        if (rw > $signed({2'b00, ANG_HALF_PI}))
        begin
            rf = rw - $signed({2'b00, ANG_PI});
            fl = 1'b1;
        end
        else if (rw < -$signed({2'b00, ANG_HALF_PI}))
        begin
            rf = rw + $signed({2'b00, ANG_PI});
            fl = 1'b1;
        end
        else
        begin
            rf = rw;
            fl = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_len_reg  <= sqr[SQRT_STEPS][31:0];
            f_r_reg    <= rf[CORDIC_BITS-1:0];
            f_flip_reg <= fl;
            f_mag_reg  <= p1c[SQRT_STEPS].mag;
            f_side_reg <= p1c[SQRT_STEPS].side;
        end
    end

    // ---------------- divider and CORDIC cells ----------------
    logic [DIV_REM_BITS-1:0]       drem [3][P2+1];
    logic [QUOT_BITS-1:0]          dq   [3][P2+1];
    logic signed [CORDIC_BITS-1:0] cx   [P2+1];
    logic signed [CORDIC_BITS-1:0] cy   [P2+1];
    logic signed [CORDIC_BITS-1:0] cr   [P2+1];
    p2_t                           p2c  [P2+1];
    logic                          vld2 [P2+1];

    for (genvar l = 0; l < 3; l++)
    begin : g_div_init
        assign drem[l][0] = {f_mag_reg[l], 30'd0};
        assign dq[l][0]   = '0;
    end

    assign cx[0]        = $signed(CORDIC_GAIN);
    assign cy[0]        = '0;
    assign cr[0]        = f_r_reg;
    assign p2c[0].side  = f_side_reg;
    assign p2c[0].len   = f_len_reg;
    assign p2c[0].flip  = f_flip_reg;
    assign vld2[0]      = f_vld_reg;

    for (genvar k = 0; k < P2; k++)
    begin : g_p2
        p2_t  c_reg;
        logic v_reg;

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            if (k < QUOT_BITS)
            begin : g_div
                aapr_div_cell #(.SHIFT(QUOT_BITS - 1 - k)) u_div (
                    .clk     (clk),
                    .en      (adv),
                    .len     (p2c[k].len),
                    .rem_in  (drem[l][k]),
                    .q_in    (dq[l][k]),
                    .rem_out (drem[l][k+1]),
                    .q_out   (dq[l][k+1])
                );
            end
            else
            begin : g_div_pass
                logic [DIV_REM_BITS-1:0] r_reg;
                logic [QUOT_BITS-1:0]    q_reg;
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        r_reg <= drem[l][k];
                        q_reg <= dq[l][k];
                    end
                end
                assign drem[l][k+1] = r_reg;
                assign dq[l][k+1]   = q_reg;
            end
        end

        if (k < NSTEP)
        begin : g_cordic
            aapr_cordic_cell #(.STEP(k)) u_cordic (
                .clk   (clk),
                .en    (adv),
                .x_in  (cx[k]),
                .y_in  (cy[k]),
                .r_in  (cr[k]),
                .x_out (cx[k+1]),
                .y_out (cy[k+1]),
                .r_out (cr[k+1])
            );
        end
        else
        begin : g_cordic_pass
            logic signed [CORDIC_BITS-1:0] x_reg;
            logic signed [CORDIC_BITS-1:0] y_reg;
            logic signed [CORDIC_BITS-1:0] r_reg;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg <= cx[k];
                    y_reg <= cy[k];
                    r_reg <= cr[k];
                end
            end
            assign cx[k+1] = x_reg;
            assign cy[k+1] = y_reg;
            assign cr[k+1] = r_reg;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                c_reg <= p2c[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= vld2[k];
        end

        assign p2c[k+1]  = c_reg;
        assign vld2[k+1] = v_reg;
    end

    // ---------------- cosine, sine, unit axis ----------------
    logic signed [CORDIC_BITS-1:0] xf;
    logic signed [CORDIC_BITS-1:0] yf;
    logic signed [31:0]            cc;
    logic signed [31:0]            sc;
    logic               m0_vld_reg;
    logic signed [31:0] m0_c_reg;
    logic signed [31:0] m0_s_reg;
    logic signed [32:0] m0_t_reg;
    logic signed [31:0] m0_u_reg [3];
    logic [QUOT_BITS-1:0] m0_q_reg [3];
    side_t              m0_side_reg;

    always_comb
    begin
        xf = p2c[P2].flip ? -cx[P2] : cx[P2];
        yf = p2c[P2].flip ? -cy[P2] : cy[P2];
        if (xf > ONE34)
            cc = ONE32;
        else if (xf < -ONE34)
            cc = -ONE32;
        else
            cc = xf[31:0];
        if (yf > ONE34)
            sc = ONE32;
        else if (yf < -ONE34)
            sc = -ONE32;
        else
            sc = yf[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_c_reg <= cc;
            m0_s_reg <= sc;
            m0_t_reg <= 33'sd1073741824 - cc;
            for (int l = 0; l < 3; l++)
            begin
                m0_q_reg[l] <= dq[l][P2];
                m0_u_reg[l] <= p2c[P2].side.sgn[l] ? -$signed({1'b0, dq[l][P2]})
                                                   : $signed({1'b0, dq[l][P2]});
            end
            m0_side_reg <= p2c[P2].side;
        end
    end

    // ---------------- (1 - cos) * u and sin * u ----------------
    logic signed [64:0] tu_full [3];
    logic signed [63:0] su_full [3];
    logic               m1_vld_reg;
    logic signed [34:0] m1_tu_reg [3];
    logic signed [33:0] m1_su_reg [3];
    logic signed [31:0] m1_u_reg  [3];
    logic signed [31:0] m1_c_reg;
    side_t              m1_side_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            tu_full[l] = m0_t_reg * m0_u_reg[l];
            su_full[l] = m0_s_reg * m0_u_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                m1_tu_reg[l] <= tu_full[l][64:30];
                m1_su_reg[l] <= su_full[l][63:30];
                m1_u_reg[l]  <= m0_u_reg[l];
            end
            m1_c_reg    <= m0_c_reg;
            m1_side_reg <= m0_side_reg;
        end
    end

    // ---------------- outer product terms ----------------
    logic signed [66:0] op_full [6];
    logic               m2_vld_reg;
    logic signed [36:0] m2_op_reg [6];
    logic signed [33:0] m2_su_reg [3];
    logic signed [31:0] m2_c_reg;
    side_t              m2_side_reg;

    // Terms in order: xx, xy, xz, yy, yz, zz.
    always_comb
    begin
        op_full[0] = m1_tu_reg[0] * m1_u_reg[0];
        op_full[1] = m1_tu_reg[0] * m1_u_reg[1];
        op_full[2] = m1_tu_reg[0] * m1_u_reg[2];
        op_full[3] = m1_tu_reg[1] * m1_u_reg[1];
        op_full[4] = m1_tu_reg[1] * m1_u_reg[2];
        op_full[5] = m1_tu_reg[2] * m1_u_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
                m2_op_reg[i] <= op_full[i][66:30];
            for (int l = 0; l < 3; l++)
                m2_su_reg[l] <= m1_su_reg[l];
            m2_c_reg    <= m1_c_reg;
            m2_side_reg <= m1_side_reg;
        end
    end

    // ---------------- matrix entries ----------------
    logic               m3_vld_reg;
    logic signed [37:0] m3_e_reg [9];
    side_t              m3_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_e_reg[0] <= m2_c_reg + m2_op_reg[0];
            m3_e_reg[1] <= m2_op_reg[1] - m2_su_reg[2];
            m3_e_reg[2] <= m2_op_reg[2] + m2_su_reg[1];
            m3_e_reg[3] <= m2_op_reg[1] + m2_su_reg[2];
            m3_e_reg[4] <= m2_c_reg + m2_op_reg[3];
            m3_e_reg[5] <= m2_op_reg[4] - m2_su_reg[0];
            m3_e_reg[6] <= m2_op_reg[2] - m2_su_reg[1];
            m3_e_reg[7] <= m2_op_reg[4] + m2_su_reg[0];
            m3_e_reg[8] <= m2_c_reg + m2_op_reg[5];
            m3_side_reg <= m2_side_reg;
        end
    end

    // ---------------- matrix times point ----------------
    logic signed [69:0] rp_full [9];
    logic signed [31:0] pcol    [3];
    logic               m4_vld_reg;
    logic signed [67:0] m4_rp_reg [9];
    side_t              m4_side_reg;

    assign pcol[0] = m3_side_reg.px;
    assign pcol[1] = m3_side_reg.py;
    assign pcol[2] = m3_side_reg.pz;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            rp_full[i] = m3_e_reg[i] * pcol[i % 3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
                m4_rp_reg[i] <= rp_full[i][69:2];
            m4_side_reg <= m3_side_reg;
        end
    end

    // ---------------- output register ----------------
    logic signed [SUM_W-1:0] row_sum [3];
    logic [31:0] out_x_reg;
    logic [31:0] out_y_reg;
    logic [31:0] out_z_reg;
    logic        out_err_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            row_sum[r] = SUM_W'(m4_rp_reg[3*r]) + SUM_W'(m4_rp_reg[3*r+1])
                       + SUM_W'(m4_rp_reg[3*r+2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // A zero axis sends the point through untouched.
            out_x_reg   <= m4_side_reg.zero ? m4_side_reg.px : round_sat(row_sum[0]);
            out_y_reg   <= m4_side_reg.zero ? m4_side_reg.py : round_sat(row_sum[1]);
            out_z_reg   <= m4_side_reg.zero ? m4_side_reg.pz : round_sat(row_sum[2]);
            out_err_reg <= m4_side_reg.zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            f_vld_reg   <= 1'b0;
            m0_vld_reg  <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            m4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            f_vld_reg   <= vld1[SQRT_STEPS];
            m0_vld_reg  <= vld2[P2];
            m1_vld_reg  <= m0_vld_reg;
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            m4_vld_reg  <= m3_vld_reg;
            out_vld_reg <= m4_vld_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.rotated_x  = out_x_reg;
    assign result.rotated_y  = out_y_reg;
    assign result.rotated_z  = out_z_reg;
    assign result.axis_error = out_err_reg;

    // ---------------- assertions ----------------
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (m0_vld_reg == $past(m0_vld_reg)) && (f_vld_reg == $past(f_vld_reg)))
        else $error("pipeline moved while the output was stalled");

    a_take_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready && !adv |=> v0_reg)
        else $error("item taken during a stall was lost");

    a_zero_axis_len: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg && f_side_reg.zero |-> (f_len_reg == 0))
        else $error("zero axis produced a nonzero length");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m0_vld_reg |-> (m0_c_reg <= ONE32) && (m0_c_reg >= -ONE32)
                       && (m0_s_reg <= ONE32) && (m0_s_reg >= -ONE32))
        else $error("cosine or sine out of range");

    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m0_vld_reg && !m0_side_reg.zero |-> (m0_q_reg[0] <= 31'd1073741824)
            && (m0_q_reg[1] <= 31'd1073741824) && (m0_q_reg[2] <= 31'd1073741824))
        else $error("unit axis component above one");

endmodule

`default_nettype wire
